// ===== rtl/core/efra_pkg.sv =====
// ----------------------------------------------------------------------------
// efra_pkg
// Types and constants shared by the earliest-free room allocator and its
// checker.
// ----------------------------------------------------------------------------
package efra_pkg;

  localparam int ROOMS_DEFAULT = 16;
  localparam int TIME_W        = 48;
  localparam int COUNT_W       = 32;
  localparam int STAMP_W       = 32;
  localparam int ROOM_W        = 4;
  localparam int CFG_W         = 5;

  localparam logic [TIME_W-1:0]  TIME_MAX        = {TIME_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};
  localparam logic [CFG_W-1:0]   ROOMS_CFG_RESET = CFG_W'(16);

  typedef struct packed {
    logic [STAMP_W-1:0] meeting_start;
    logic [STAMP_W-1:0] meeting_end;
  } req_t;

  typedef struct packed {
    logic [ROOM_W-1:0]  assigned_room;
    logic [TIME_W-1:0]  finish_time;
    logic               was_delayed;
    logic [ROOM_W-1:0]  busiest_room;
    logic [COUNT_W-1:0] busiest_count;
  } rsp_t;

  typedef struct packed {
    logic [TIME_W-1:0]  busy_until;
    logic [COUNT_W-1:0] booking_count;
  } room_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

// ===== rtl/core/earliest_free_room_allocator.sv =====
// ----------------------------------------------------------------------------
// earliest_free_room_allocator
// Books each request into the lowest free enabled room, or delays it into the
// room that frees earliest, and reports the most-booked room.
// ----------------------------------------------------------------------------
// One request is handled at a time: the beat is taken, the single read port of
// the room memory walks rooms 0 to n-1, n being the number of enabled rooms,
// the read data is registered, and the chosen room is written back and the
// result is loaded into the output register once any stalled previous result
// has left the output. Room state lives in one memory of ROOMS
// entries; a valid bit per entry, cleared at reset, makes an unwritten room
// read as free with no bookings, so no clearing pass is needed after reset.
// The result register frees the input side: a new request is taken while the
// previous result still waits on the output.
module earliest_free_room_allocator #(
  parameter int ROOMS = efra_pkg::ROOMS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  efra_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output efra_pkg::rsp_t             rsp,
  input  logic                       cfg_wr_en,
  input  logic [efra_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int CNT_W = $clog2(ROOMS + 1);
  localparam int N_W   = (CNT_W > efra_pkg::CFG_W) ? CNT_W : efra_pkg::CFG_W;

  efra_pkg::state_t state, state_next;

  logic [efra_pkg::CFG_W-1:0] rooms_in_use;
  logic [N_W-1:0]             cfg_ext;
  logic [N_W-1:0]             n_eff;
  logic [IDX_W-1:0]           last_idx;

  efra_pkg::room_entry_t room_mem [ROOMS];
  logic [ROOMS-1:0]      room_valid;

  logic [IDX_W-1:0]      rd_idx;
  logic                  issuing;
  efra_pkg::room_entry_t rd_entry;
  logic                  rd_entry_valid;
  logic                  dv;
  logic [IDX_W-1:0]      d_idx;

  logic [efra_pkg::TIME_W-1:0]  d_busy;
  logic [efra_pkg::COUNT_W-1:0] d_count;

  logic [efra_pkg::STAMP_W-1:0] start;
  logic [efra_pkg::STAMP_W-1:0] stop;
  logic [efra_pkg::STAMP_W-1:0] dur;

  logic                         found;
  logic [IDX_W-1:0]             pick;
  logic [efra_pkg::COUNT_W-1:0] pick_count;
  logic [IDX_W-1:0]             earl;
  logic [efra_pkg::TIME_W-1:0]  earl_busy;
  logic [efra_pkg::COUNT_W-1:0] earl_count;
  logic [IDX_W-1:0]             best;
  logic [efra_pkg::COUNT_W-1:0] best_count;

  logic                         commit;
  logic                         accept;
  logic [IDX_W-1:0]             chosen;
  logic [efra_pkg::COUNT_W-1:0] chosen_count;
  logic [efra_pkg::COUNT_W-1:0] new_count;
  logic [efra_pkg::TIME_W:0]    delay_sum;
  logic [efra_pkg::TIME_W-1:0]  finish;
  logic                         pick_wins;

  // enabled room count
  always_comb begin
    cfg_ext = N_W'(rooms_in_use);
    if (cfg_ext == '0) begin
      n_eff = N_W'(1);
    end else if (cfg_ext > N_W'(ROOMS)) begin
      n_eff = N_W'(ROOMS);
    end else begin
      n_eff = cfg_ext;
    end
    last_idx = IDX_W'(n_eff - N_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rooms_in_use <= efra_pkg::ROOMS_CFG_RESET;
    end else if (cfg_wr_en) begin
      rooms_in_use <= cfg_wr_data;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    accept     = 1'b0;
    commit     = 1'b0;
    case (state)
      efra_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        accept    = req_valid;
        if (req_valid) begin
          state_next = efra_pkg::ST_SCAN;
        end
      end
      efra_pkg::ST_SCAN: begin
        if (dv && d_idx == last_idx) begin
          state_next = efra_pkg::ST_WRITE;
        end
      end
      efra_pkg::ST_WRITE: begin
        commit = !rsp_valid || !rsp_stall;
        if (commit) begin
          state_next = efra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = efra_pkg::ST_IDLE;
      end
    endcase
  end

  // room memory read port
  always_ff @(posedge clk) begin
    rd_entry       <= room_mem[rd_idx];
    rd_entry_valid <= room_valid[rd_idx];
    d_idx          <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      dv      <= 1'b0;
      rd_idx  <= '0;
    end else begin
      dv <= issuing;
      if (accept) begin
        issuing <= 1'b1;
        rd_idx  <= '0;
      end else if (issuing) begin
        if (rd_idx == last_idx) begin
          issuing <= 1'b0;
        end else begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
      end
    end
  end

  assign d_busy  = rd_entry_valid ? rd_entry.busy_until : '0;
  assign d_count = rd_entry_valid ? rd_entry.booking_count : '0;

  // scan of room state
  always_ff @(posedge clk) begin
    if (accept) begin
      start <= req.meeting_start;
      stop  <= req.meeting_end;
      dur   <= (req.meeting_end > req.meeting_start) ?
               req.meeting_end - req.meeting_start : '0;
      found <= 1'b0;
    end else if (dv) begin
      if (!found) begin
        if (d_busy <= efra_pkg::TIME_W'(start)) begin
          found      <= 1'b1;
          pick       <= d_idx;
          pick_count <= d_count;
        end else if (d_idx == '0 || d_busy < earl_busy) begin
          earl       <= d_idx;
          earl_busy  <= d_busy;
          earl_count <= d_count;
        end
      end
      if (d_idx == '0 || d_count > best_count) begin
        best       <= d_idx;
        best_count <= d_count;
      end
    end
  end

  // write-back and result
  always_comb begin
    chosen       = found ? pick : earl;
    chosen_count = found ? pick_count : earl_count;
    new_count    = (chosen_count == efra_pkg::COUNT_MAX) ?
                   chosen_count : chosen_count + efra_pkg::COUNT_W'(1);
    delay_sum    = {1'b0, earl_busy} + (efra_pkg::TIME_W + 1)'(dur);
    if (found) begin
      finish = efra_pkg::TIME_W'((stop > start) ? stop : start);
    end else if (delay_sum > {1'b0, efra_pkg::TIME_MAX}) begin
      finish = efra_pkg::TIME_MAX;
    end else begin
      finish = delay_sum[efra_pkg::TIME_W-1:0];
    end
    pick_wins = (new_count > best_count) ||
                (new_count == best_count && chosen < best);
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      room_mem[chosen] <= '{busy_until: finish, booking_count: new_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      room_valid <= '0;
    end else if (commit) begin
      room_valid[chosen] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.assigned_room <= efra_pkg::ROOM_W'(chosen);
      rsp.finish_time   <= finish;
      rsp.was_delayed   <= !found;
      rsp.busiest_room  <= efra_pkg::ROOM_W'(pick_wins ? chosen : best);
      rsp.busiest_count <= pick_wins ? new_count : best_count;
    end
  end

endmodule

// ===== rtl/core/efra_checker.sv =====
// ----------------------------------------------------------------------------
// efra_checker
// Port-level checks for the earliest-free room allocator, bound to its top.
// ----------------------------------------------------------------------------
module efra_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input efra_pkg::rsp_t rsp
);

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while another is in work");

  // a result only follows work on a request
  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result appeared with no request in work");

  // a booked room always exists
  a_busiest_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.busiest_count != '0)
    else $error("busiest count is zero after a booking");

  // an undelayed booking ends within the request's time range
  a_free_finish: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.was_delayed |-> rsp.finish_time[47:32] == '0)
    else $error("undelayed finish time beyond request range");

endmodule

bind earliest_free_room_allocator efra_checker u_efra_checker (.*);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for earliest_free_room_allocator. A model of the room
// table predicts every booking when its request beat is taken, and each
// result beat is checked field by field against the oldest prediction. The
// run covers directed bookings, room-count settings, random traffic with
// random gaps and stalls on both sides, a long output hold-off, extreme
// field values and long delays that carry the finish time past 32 bits.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import efra_pkg::*;

  localparam int ROOMS = ROOMS_DEFAULT;
  localparam int LONG_BOOKINGS = 16;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]     cfg_wr_data = '0;

  logic [TIME_W-1:0]    room_busy_until [ROOMS];
  logic [COUNT_W-1:0]   room_bookings [ROOMS];
  logic [CFG_W-1:0]     rooms_setting = ROOMS_CFG_RESET;
  rsp_t                 expected_bookings [$];

  bit                   send_idle = 1'b1;
  bit                   recv_idle = 1'b1;
  int                   hold_left = 0;
  int                   mismatches = 0;

  earliest_free_room_allocator #(
    .ROOMS(ROOMS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAIL earliest_free_room_allocator");
    $finish;
  end

  function automatic int rooms_enabled();
    if (rooms_setting == 0) begin
      return 1;
    end
    if (rooms_setting > ROOMS) begin
      return ROOMS;
    end
    return int'(rooms_setting);
  endfunction

  // allocate one request in the room table and queue the result it must give
  function automatic void book_request(input logic [STAMP_W-1:0] s,
                                       input logic [STAMP_W-1:0] e);
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] fin;
    logic [TIME_W:0]   sum;
    int                n;
    int                k;
    int                pick;
    int                earliest;
    int                best;
    bit                found;
    rsp_t              r;
    n = rooms_enabled();
    dur = (e > s) ? TIME_W'(e - s) : '0;
    pick = 0;
    earliest = 0;
    found = 1'b0;
    for (k = 0; k < n; k++) begin
      if (!found) begin
        if (room_busy_until[k] <= TIME_W'(s)) begin
          pick = k;
          found = 1'b1;
        end else if (room_busy_until[k] < room_busy_until[earliest]) begin
          earliest = k;
        end
      end
    end
    if (found) begin
      fin = TIME_W'(s) + dur;
    end else begin
      pick = earliest;
      sum = {1'b0, room_busy_until[pick]} + {1'b0, dur};
      fin = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    end
    room_busy_until[pick] = fin;
    if (room_bookings[pick] != COUNT_MAX) begin
      room_bookings[pick] = room_bookings[pick] + 1'b1;
    end
    best = 0;
    for (k = 1; k < n; k++) begin
      if (room_bookings[k] > room_bookings[best]) begin
        best = k;
      end
    end
    r.assigned_room = ROOM_W'(pick);
    r.finish_time   = fin;
    r.was_delayed   = !found;
    r.busiest_room  = ROOM_W'(best);
    r.busiest_count = room_bookings[best];
    expected_bookings.push_back(r);
  endfunction

  function automatic void flag_field(input string name, input logic [63:0] want,
                                     input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // result beat check
  always @(posedge clk) begin : check_bookings
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (expected_bookings.size() == 0) begin
        mismatches++;
        $display("%0t: result beat expected none actual 0x%0h", $time, rsp);
      end else begin
        want = expected_bookings.pop_front();
        flag_field("assigned_room", want.assigned_room, rsp.assigned_room);
        flag_field("finish_time", want.finish_time, rsp.finish_time);
        flag_field("was_delayed", want.was_delayed, rsp.was_delayed);
        flag_field("busiest_room", want.busiest_room, rsp.busiest_room);
        flag_field("busiest_count", want.busiest_count, rsp.busiest_count);
      end
    end
  end

  // receiver stall, with a long hold-off on request
  initial begin : drive_rsp_stall
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
        wait_left = recv_idle ? $urandom_range(0, 6) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(input logic [STAMP_W-1:0] s,
                              input logic [STAMP_W-1:0] e);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{meeting_start: s, meeting_end: e};
    do @(posedge clk); while (req_stall !== 1'b0);
    book_request(s, e);
  endtask

  task automatic drain_bookings();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_bookings.size() != 0);
  endtask

  task automatic write_rooms(input logic [CFG_W-1:0] v);
    drain_bookings();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rooms_setting = v;
  endtask

  task automatic test_first_bookings();
    int k;
    send_request(32'd0, 32'd10);
    send_request(32'd0, 32'd0);
    send_request(32'd0, 32'd5);
    for (k = 2; k < ROOMS; k++) begin
      send_request(32'd1, 32'd100);
    end
    send_request(32'd2, 32'd50);
    send_request(32'd2, 32'd1);
    send_request(32'd3, 32'd103);
    send_request(32'd60, 32'd60);
    send_request(32'd60, 32'd160);
    send_request(32'd61, 32'd70);
    // start earlier than the previous request
    send_request(32'd50, 32'd55);
    drain_bookings();
  endtask

  task automatic test_room_count();
    write_rooms(CFG_W'(1));
    send_request(32'd200, 32'd210);
    send_request(32'd200, 32'd220);
    write_rooms(CFG_W'(0));
    send_request(32'd201, 32'd205);
    write_rooms(CFG_W'(31));
    send_request(32'd205, 32'd215);
    write_rooms(CFG_W'(17));
    send_request(32'd206, 32'd206);
    write_rooms(CFG_W'(ROOMS));
    send_request(32'd207, 32'd300);
    drain_bookings();
  endtask

  task automatic test_random_traffic();
    int unsigned       clock_now;
    int                phase;
    int                k;
    logic [STAMP_W-1:0] s;
    logic [STAMP_W-1:0] e;
    clock_now = 1000;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_rooms(CFG_W'(1));
        1: write_rooms(CFG_W'(ROOMS));
        default: write_rooms(CFG_W'($urandom_range(0, 31)));
      endcase
      case (phase % 4)
        0: begin send_idle = 1'b1; recv_idle = 1'b1; end
        1: begin send_idle = 1'b0; recv_idle = 1'b0; end
        2: begin send_idle = 1'b1; recv_idle = 1'b0; end
        default: begin send_idle = 1'b0; recv_idle = 1'b1; end
      endcase
      for (k = 0; k < 200; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          s = clock_now - $urandom_range(0, 300);
          e = $urandom_range(0, 1) ? s : s - $urandom_range(0, 50);
        end else begin
          clock_now += $urandom_range(0, 12);
          if ($urandom_range(0, 49) == 0) begin
            clock_now += 1500;
          end
          s = clock_now;
          e = s + $urandom_range(1, 10 * rooms_enabled());
        end
        send_request(s, e);
      end
    end
    drain_bookings();
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    int k;
    int unsigned clock_now;
    write_rooms(CFG_W'(4));
    send_idle = 1'b0;
    hold_left = 300;
    clock_now = 200000;
    for (k = 0; k < 24; k++) begin
      clock_now += $urandom_range(0, 5);
      send_request(clock_now, clock_now + $urandom_range(1, 40));
    end
    drain_bookings();
    send_idle = 1'b1;
  endtask

  task automatic test_field_extremes();
    write_rooms(CFG_W'(ROOMS));
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'h0000_0000);
    send_request(32'h5555_5555, 32'hAAAA_AAAA);
    send_request(32'hAAAA_AAAA, 32'h5555_5555);
    send_request(32'h0000_0000, 32'hFFFF_FFFF);
    drain_bookings();
  endtask

  // one room, repeated full-length delayed bookings that grow its finish time
  task automatic test_long_delays();
    int k;
    write_rooms(CFG_W'(1));
    send_idle = 1'b0;
    recv_idle = 1'b0;
    for (k = 0; k < LONG_BOOKINGS; k++) begin
      send_request(32'h0000_0000, 32'hFFFF_FFFF);
    end
    drain_bookings();
  endtask

  initial begin
    int k;
    for (k = 0; k < ROOMS; k++) begin
      room_busy_until[k] = '0;
      room_bookings[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_first_bookings();
    test_room_count();
    test_random_traffic();
    test_backpressure();
    test_field_extremes();
    test_long_delays();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_bookings.size() == 0) begin
      $display("PASS earliest_free_room_allocator");
    end else begin
      $display("FAIL earliest_free_room_allocator");
    end
    $finish;
  end

endmodule
